// ----- design/rws_pkg.sv -----
// ----------------------------------------------------------------------------
// rws_pkg: shared types and constants of the roulette-wheel selector
// Table geometry, arithmetic widths, item codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int RAND_BITS   = 16;

  localparam int IDX_W    = $clog2(MAX_ENTRIES);
  localparam int CNT_W    = IDX_W + 1;          // holds 0..MAX_ENTRIES
  localparam int WEIGHT_W = 6;
  localparam int EFFW_W   = 2 * WEIGHT_W;       // weight squared
  localparam int SUM_W    = EFFW_W + IDX_W;     // sum of all effective weights
  localparam int DICE_W   = SUM_W + RAND_BITS;
  localparam int CFG_W    = 7;                  // entry_count register
  localparam int OUT_IDX_W = 7;                 // selected_index field
  localparam int FUNC_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SELECT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SCALE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept_sel;  // capture select item, restart walk counter
    logic wr_weight;   // write table entry
    logic clr_mask;    // empty exclusion mask
    logic sum_en;      // summing walk
    logic scale_en;    // dice = total * fraction, restart walk
    logic search_en;   // searching walk
    logic emit;        // move result into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic pass_end;    // walk has issued every entry in use
    logic hit;         // searching walk found the entry this cycle
    logic out_free;    // output register can take a result
  } dp_status_t;

endpackage

// ----- design/rws_ram.sv -----
// ----------------------------------------------------------------------------
// rws_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module rws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rws_ctrl.sv -----
// ----------------------------------------------------------------------------
// rws_ctrl: sequencing controller of the roulette-wheel selector
// Takes items in idle, runs the summing walk, the scaling step and the
// searching walk for a select, then hands the result to the output register.
// ----------------------------------------------------------------------------
module rws_ctrl
  import rws_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FUNC_W-1:0] func_i,
  input  dp_status_t        status_i,
  output ctrl_cmd_t         cmd_o,
  output logic              in_stall_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && func_i == FUNC_SELECT) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (status_i.pass_end) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status_i.hit || status_i.pass_end) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept_sel = accept && (func_i == FUNC_SELECT);
        cmd_o.wr_weight  = accept && (func_i == FUNC_WRITE);
        cmd_o.clr_mask   = accept && (func_i == FUNC_CLEAR);
      end
      ST_SUM:    cmd_o.sum_en    = 1'b1;
      ST_SCALE:  cmd_o.scale_en  = 1'b1;
      ST_SEARCH: cmd_o.search_en = 1'b1;
      ST_EMIT:   cmd_o.emit      = status_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- design/rws_dp.sv -----
// ----------------------------------------------------------------------------
// rws_dp: datapath of the roulette-wheel selector
// Weight RAM, exclusion mask, walk counter, total/floor accumulators, dice
// multiplier, result and output registers.
// ----------------------------------------------------------------------------
module rws_dp
  import rws_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [IDX_W-1:0]     entry_index_i,
  input  logic [WEIGHT_W-1:0]  weight_i,
  input  logic [RAND_BITS-1:0] random_value_i,
  input  logic                 square_weights_i,
  input  logic                 exclude_selected_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [OUT_IDX_W-1:0] selected_index_o,
  output logic                 none_found_o
);

  logic [CFG_W-1:0]       count_q;
  logic [CNT_W-1:0]       n_in_use;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   issue;
  logic                   pend_q;
  logic [IDX_W-1:0]       pidx_q;
  logic [RAND_BITS-1:0]   rnd_q;
  logic                   sq_q, excl_q;
  logic [MAX_ENTRIES-1:0] mask_q;
  logic [WEIGHT_W-1:0]    rdata;
  logic [EFFW_W-1:0]      w_sq, w_eff;
  logic                   usable;
  logic [SUM_W-1:0]       total_q, floor_q, reach;
  logic [DICE_W-1:0]      dice_q, dice_d;
  logic                   hit;
  logic [OUT_IDX_W-1:0]   res_idx_q;
  logic                   res_nf_q;
  logic                   out_valid_q;
  logic [OUT_IDX_W-1:0]   out_idx_q;
  logic                   out_nf_q;

  // entry_count saturates to the table size
  always_comb begin
    if (int'(count_q) > MAX_ENTRIES) n_in_use = CNT_W'(MAX_ENTRIES);
    else                             n_in_use = CNT_W'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  rws_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_weight),
    .waddr_i (entry_index_i),
    .wdata_i (weight_i),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // walk: address issued from cnt_q, data in the next cycle tagged by pidx_q
  assign issue = (cnt_q < n_in_use);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.accept_sel || cmd_i.scale_en) begin
      cnt_d = '0;
    end else if ((cmd_i.sum_en || cmd_i.search_en) && issue) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= (cmd_i.sum_en || cmd_i.search_en) && issue && !hit;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q[IDX_W-1:0];
  end

  assign w_sq   = {{WEIGHT_W{1'b0}}, rdata} * {{WEIGHT_W{1'b0}}, rdata};
  assign w_eff  = sq_q ? w_sq : EFFW_W'(rdata);
  assign usable = pend_q && !mask_q[pidx_q];

  // chosen when total*r <= (floor + w) * 2^RAND_BITS
  assign reach  = floor_q + SUM_W'(w_eff);
  assign hit    = cmd_i.search_en && usable && (dice_q <= {reach, {RAND_BITS{1'b0}}});
  assign dice_d = total_q * rnd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_sel) begin
      rnd_q   <= random_value_i;
      sq_q    <= square_weights_i;
      excl_q  <= exclude_selected_i;
      total_q <= '0;
    end else if (cmd_i.sum_en && usable) begin
      total_q <= total_q + SUM_W'(w_eff);
    end
    if (cmd_i.scale_en) begin
      dice_q  <= dice_d;
      floor_q <= '0;
    end else if (cmd_i.search_en && usable) begin
      floor_q <= reach;
    end
    if (cmd_i.search_en && (hit || !issue)) begin
      res_idx_q <= hit ? OUT_IDX_W'(pidx_q) : OUT_IDX_W'(n_in_use);
      res_nf_q  <= !hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cmd_i.clr_mask) begin
      mask_q <= '0;
    end else if (hit && excl_q) begin
      mask_q[pidx_q] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_idx_q <= res_idx_q;
      out_nf_q  <= res_nf_q;
    end
  end

  assign status_o.pass_end = !issue;
  assign status_o.hit      = hit;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign selected_index_o = out_idx_q;
  assign none_found_o     = out_nf_q;

endmodule

// ----- design/roulette_wheel_select.sv -----
// ----------------------------------------------------------------------------
// roulette_wheel_select: fitness-proportionate selector over a weight table
// Stores 6-bit weights, keeps an exclusion mask and draws one entry per
// select item with probability proportional to its (optionally squared)
// weight among the entries in use that are not excluded.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): an item is taken when valid is
//   high and stall is low. func_i picks a weight write, a select or a clear
//   of the exclusion mask; code 3 is dropped. Only a select gives a result.
//   Output channel (out_valid_o / out_stall_i): one result per select, held
//   in an output register until the receiver drops stall.
//   Configuration (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the
//   entry_count register; always ready, write only while idle.
// Sequencing:
//   Write, clear and unused items are taken in idle and keep the block idle.
//   A select runs the summing walk, the dice multiply, the searching walk,
//   which ends at the first hit or after the last entry in use, and the
//   hand-over of the result. Both walks read the weight RAM through its one
//   read port, one entry per cycle.
//   A pending result does not block the next item; only a finished select
//   waits in its hand-over step while the output register is still full.
// Reset: entry_count is 0, the exclusion mask is empty, no result pending.
//   Table weights are undefined until written.
// ----------------------------------------------------------------------------
module roulette_wheel_select
  import rws_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [IDX_W-1:0]     entry_index_i,
  input  logic [WEIGHT_W-1:0]  weight_i,
  input  logic [RAND_BITS-1:0] random_value_i,
  input  logic                 square_weights_i,
  input  logic                 exclude_selected_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_IDX_W-1:0] selected_index_o,
  output logic                 none_found_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // register write never stalls
  assign cfg_ready_o = 1'b1;

  rws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  rws_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .entry_index_i      (entry_index_i),
    .weight_i           (weight_i),
    .random_value_i     (random_value_i),
    .square_weights_i   (square_weights_i),
    .exclude_selected_i (exclude_selected_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .selected_index_o   (selected_index_o),
    .none_found_o       (none_found_o)
  );

endmodule

// ----- design/rws_chk.sv -----
// ----------------------------------------------------------------------------
// rws_chk: port-level checker for the roulette-wheel selector
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module rws_chk
  import rws_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [FUNC_W-1:0]    func_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [OUT_IDX_W-1:0] selected_index_o,
  input logic                 none_found_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted select keeps the input side busy
  a_sel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FUNC_SELECT |=> in_stall_o)
    else $error("select item did not start a walk");

  // a new result only comes out of a running select
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a select in progress");

  // a found entry lies inside the table
  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !none_found_o |-> (selected_index_o < OUT_IDX_W'(MAX_ENTRIES)))
    else $error("selected index beyond table");

endmodule

bind roulette_wheel_select rws_chk u_rws_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .func_i           (func_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .selected_index_o (selected_index_o),
  .none_found_o     (none_found_o)
);

// ----- test/tb_roulette_wheel_select.sv -----
// ----------------------------------------------------------------------------
// tb_roulette_wheel_select: self-checking bench for the roulette-wheel selector
// Fills the weight table, runs directed selects on zero totals, full
// exclusion, dice boundaries and count saturation, then random item mixes
// over several entry counts and idle/stall patterns. A scoreboard predicts
// each pick and checks every result item in order.
// ----------------------------------------------------------------------------
module tb_roulette_wheel_select;
  import rws_pkg::*;

  // func code the block drops without a result
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // a select walks the table twice; give the last one room to finish
  localparam int SETTLE_CYCLES = 2 * MAX_ENTRIES + 16;
  localparam int NUM_PHASES    = 9;
  localparam int PRESSURE_PHASE = 3;

  // random phases: entry_count, sender idle %, receiver stall %, items
  localparam int PHASE_COUNT [NUM_PHASES] = '{64, 1, 3, 64, 0, 127, 6, 17, 64};
  localparam int PHASE_IDLE  [NUM_PHASES] = '{ 0, 73, 0, 28, 0, 73, 28, 0, 0};
  localparam int PHASE_STALL [NUM_PHASES] = '{ 0, 0, 73, 28, 0, 0, 28, 73, 0};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{100, 70, 100, 100, 30, 70, 130, 90, 50};

  typedef struct {
    logic [OUT_IDX_W-1:0] sel_index;
    logic                 none;
  } wheel_pick_t;

  // --------------------------------------------------------------------------
  // Scoreboard: private copy of table, mask and count; predicts each select
  // --------------------------------------------------------------------------
  class wheel_scoreboard;
    logic [WEIGHT_W-1:0] weights [MAX_ENTRIES];
    bit                  excluded [MAX_ENTRIES];
    logic [CFG_W-1:0]    entry_count;
    wheel_pick_t         pending_picks [$];
    int unsigned         errors;

    function new();
      foreach (weights[i]) begin
        weights[i]  = '0;
        excluded[i] = 1'b0;
      end
      entry_count = '0;
      errors      = 0;
    endfunction

    function longint unsigned eff_weight(int idx, logic sq);
      longint unsigned w;
      w = weights[idx];
      return sq ? w * w : w;
    endfunction

    function void note_item(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                            logic [WEIGHT_W-1:0] w, logic [RAND_BITS-1:0] frac,
                            logic sq, logic ex);
      int unsigned     n;
      int unsigned     chosen;
      bit              found;
      longint unsigned total;
      longint unsigned dice;
      longint unsigned floor_sum;
      wheel_pick_t     pick;
      case (f)
        FUNC_WRITE: weights[idx] = w;
        FUNC_CLEAR: foreach (excluded[i]) excluded[i] = 1'b0;
        FUNC_SELECT: begin
          // counts above the table size saturate
          n = (entry_count > MAX_ENTRIES) ? MAX_ENTRIES : entry_count;
          total = 0;
          for (int i = 0; i < n; i++)
            if (!excluded[i]) total += eff_weight(i, sq);
          dice      = total * longint'(frac);
          floor_sum = 0;
          chosen    = n;
          found     = 1'b0;
          // inclusive test: a zero dice lands on the first usable entry
          for (int i = 0; i < n && !found; i++) begin
            if (!excluded[i]) begin
              if (dice <= ((floor_sum + eff_weight(i, sq)) << RAND_BITS)) begin
                chosen = i;
                found  = 1'b1;
              end else begin
                floor_sum += eff_weight(i, sq);
              end
            end
          end
          if (found && ex) excluded[chosen] = 1'b1;
          pick.sel_index = OUT_IDX_W'(chosen);
          pick.none      = !found;
          pending_picks.insert(pending_picks.size(), pick);
        end
        default: ;
      endcase
    endfunction

    function void check_pick(logic [OUT_IDX_W-1:0] sel_index, logic none);
      wheel_pick_t exp_pick;
      if (pending_picks.size() == 0) begin
        $error("unexpected result item: selected_index %0d none_found %0d",
               sel_index, none);
        errors++;
        return;
      end
      exp_pick = pending_picks.pop_front();
      if (sel_index !== exp_pick.sel_index) begin
        $error("selected_index: expected %0d, got %0d", exp_pick.sel_index, sel_index);
        errors++;
      end
      if (none !== exp_pick.none) begin
        $error("none_found: expected %0d, got %0d", exp_pick.none, none);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [FUNC_W-1:0]    func_i;
  logic [IDX_W-1:0]     entry_index_i;
  logic [WEIGHT_W-1:0]  weight_i;
  logic [RAND_BITS-1:0] random_value_i;
  logic                 square_weights_i;
  logic                 exclude_selected_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [OUT_IDX_W-1:0] selected_index_o;
  logic                 none_found_o;

  roulette_wheel_select u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .entry_index_i      (entry_index_i),
    .weight_i           (weight_i),
    .random_value_i     (random_value_i),
    .square_weights_i   (square_weights_i),
    .exclude_selected_i (exclude_selected_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .selected_index_o   (selected_index_o),
    .none_found_o       (none_found_o)
  );

  wheel_scoreboard sb;
  int tx_idle_pct;   // chance per cycle that the sender holds back
  int rx_stall_pct;  // chance per cycle that the receiver stalls

  // 4-unit clock, first rising edge at 2
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: random stall per cycle, independent of out_valid_o
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  // Input monitor: every accepted item goes to the predictor.
  // Sampled at the edge, before any of this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_item(func_i, entry_index_i, weight_i, random_value_i,
                   square_weights_i, exclude_selected_i);
  end

  // Output monitor: every accepted result item is checked in order
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_pick(selected_index_o, none_found_o);
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Present one item after a random gap; hold it until it is taken.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                           input logic [WEIGHT_W-1:0] w,
                           input logic [RAND_BITS-1:0] frac,
                           input logic sq, input logic ex);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    func_i             <= f;
    entry_index_i      <= idx;
    weight_i           <= w;
    random_value_i     <= frac;
    square_weights_i   <= sq;
    exclude_selected_i <= ex;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Weights lean toward the extremes now and then
  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return WEIGHT_W'($urandom_range(63));
    endcase
  endfunction

  // Sender stops; wait until every pending pick has come back
  task automatic drain_picks();
    in_valid_i <= 1'b0;
    while (sb.pending_picks.size() != 0) @(posedge clk_i);
  endtask

  // entry_count is written only with the block idle
  task automatic write_entry_count(input logic [CFG_W-1:0] cnt);
    drain_picks();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cnt;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.entry_count = cnt;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly selects with writes mixed in; clears and dropped codes are rarer.
  // Ignored items do not count toward the phase length.
  task automatic send_random_item(output bit counted);
    int                   roll;
    logic [FUNC_W-1:0]    f;
    logic [RAND_BITS-1:0] frac;
    roll = $urandom_range(99);
    if (roll < 4)       f = FUNC_UNUSED;
    else if (roll < 10) f = FUNC_CLEAR;
    else if (roll < 38) f = FUNC_WRITE;
    else                f = FUNC_SELECT;
    case ($urandom_range(7))
      0:       frac = '0;
      1:       frac = '1;
      default: frac = RAND_BITS'($urandom_range(65535));
    endcase
    counted = (f != FUNC_UNUSED);
    send_item(f, IDX_W'($urandom_range(MAX_ENTRIES - 1)), rand_weight(), frac,
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int  done_items;
    bit  counted;
    logic [WEIGHT_W-1:0] w;

    sb = new();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rst_ni             <= 1'b0;
    cfg_valid_i        <= 1'b0;
    cfg_data_i         <= '0;
    in_valid_i         <= 1'b0;
    func_i             <= FUNC_WRITE;
    entry_index_i      <= '0;
    weight_i           <= '0;
    random_value_i     <= '0;
    square_weights_i   <= 1'b0;
    exclude_selected_i <= 1'b0;
    out_stall_i        <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- entry_count 0 straight out of reset: no entries in use ---
    send_item(FUNC_SELECT, '0, '0, 16'hFFFF, 1'b1, 1'b1);
    send_item(FUNC_UNUSED, '1, '1, '1, 1'b1, 1'b1);

    // Fill the whole table so no select ever reads an unwritten entry
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (i == 1)      w = '0;
      else if (i == 2) w = '1;
      else             w = rand_weight();
      send_item(FUNC_WRITE, IDX_W'(i), w, RAND_BITS'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    end

    // --- two entries: zero total, exclusion until none left, dice edges ---
    write_entry_count(CFG_W'(2));
    send_item(FUNC_WRITE, 6'd0, '0, '0, 1'b0, 1'b0);
    send_item(FUNC_WRITE, 6'd1, '0, '0, 1'b0, 1'b0);
    send_item(FUNC_SELECT, '0, '0, 16'hFFFF, 1'b0, 1'b1);   // zero total -> entry 0
    send_item(FUNC_SELECT, '0, '0, 16'hFFFF, 1'b1, 1'b1);   // only entry 1 left
    send_item(FUNC_SELECT, '0, '0, 16'h1234, 1'b0, 1'b1);   // all excluded
    send_item(FUNC_CLEAR, '0, '0, '0, 1'b0, 1'b0);
    send_item(FUNC_WRITE, 6'd0, '1, '0, 1'b0, 1'b0);
    send_item(FUNC_WRITE, 6'd1, '1, '0, 1'b0, 1'b0);
    send_item(FUNC_SELECT, '0, '0, '0, 1'b1, 1'b0);         // dice zero
    send_item(FUNC_SELECT, '0, '0, 16'hFFFF, 1'b1, 1'b0);   // dice at the top end -> entry 1
    send_item(FUNC_SELECT, '0, '0, 16'h8000, 1'b1, 1'b0);   // dice exactly on the edge
    send_item(FUNC_SELECT, '0, '0, 16'h8001, 1'b0, 1'b0);

    // --- count above the table size saturates ---
    write_entry_count(CFG_W'(127));
    send_item(FUNC_SELECT, '0, '0, 16'hFFFF, 1'b0, 1'b0);
    send_item(FUNC_SELECT, '0, '0, 16'h0001, 1'b1, 1'b1);
    send_item(FUNC_CLEAR, '0, '0, '0, 1'b0, 1'b0);

    // --- random phases over counts and idle/stall patterns ---
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_entry_count(CFG_W'(PHASE_COUNT[p]));
      tx_idle_pct  = PHASE_IDLE[p];
      rx_stall_pct = PHASE_STALL[p];
      done_items   = 0;
      while (done_items < PHASE_ITEMS[p]) begin
        send_random_item(counted);
        if (counted) begin
          done_items++;
          // sender holds off until the pipe is empty, once
          if (p == PRESSURE_PHASE && done_items == PHASE_ITEMS[p] / 2)
            drain_picks();
        end
      end
    end

    drain_picks();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_roulette_wheel_select OK");
    end else begin
      $display("tb_roulette_wheel_select NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #6000000;
    $display("tb_roulette_wheel_select NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
design/rws_pkg.sv
design/rws_ram.sv
design/rws_ctrl.sv
design/rws_dp.sv
design/roulette_wheel_select.sv
design/rws_chk.sv
test/tb_roulette_wheel_select.sv
